// ===== sv/polynomial_newton_root_finder_unit_assert.svh =====
// Assertion macros for the root finder, clocked on i_clk, off during reset
`ifndef POLYNOMIAL_NEWTON_ROOT_FINDER_UNIT_ASSERT_SVH
`define POLYNOMIAL_NEWTON_ROOT_FINDER_UNIT_ASSERT_SVH

// same-cycle implication
`define PNR_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("pnr assertion failed");

// next-cycle implication
`define PNR_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("pnr assertion failed");

`endif

// ===== sv/pnr_pkg.sv =====
package pnr_pkg;

    // Q16.32 word
    localparam int Q_W        = 48;
    localparam int TOL_W      = 47;
    localparam int STAT_W     = 2;
    localparam int ITER_OUT_W = 7;
    localparam int CFG_ADDR_W = 1;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // parameter defaults
    localparam int MAX_DEGREE_DEF     = 9;
    localparam int MAX_ITERATIONS_DEF = 64;

    // register reset values
    localparam logic signed [Q_W-1:0] GUESS_RST = 48'sh0001_0000_0000;
    localparam logic [TOL_W-1:0]      TOL_RST   = 47'd42950;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_GUESS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE     = 1'd1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_CONVERGED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_DERIV = 2'd1;
    localparam logic [STAT_W-1:0] ST_ITER_LIMIT = 2'd2;
    localparam logic [STAT_W-1:0] ST_SATURATED  = 2'd3;

    // result word of the multiply and divide units
    typedef struct packed {
        logic                 done;
        logic                 sat;
        logic [Q_W-1:0]       value;
    } t_unit_out;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_HCHK,
        S_MDP,
        S_MP,
        S_EVAL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== sv/pnr_mul.sv =====
// Saturating Q16.32 multiply, accumulating four 24x24 partial products
module pnr_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pnr_pkg::Q_W-1:0]     i_a,
    input  logic [pnr_pkg::Q_W-1:0]     i_b,
    output pnr_pkg::t_unit_out          o_res
);

    localparam int H_W = pnr_pkg::Q_W / 2;
    localparam int P_W = 2 * pnr_pkg::Q_W;

    logic                     r_run, r_fin;
    logic [1:0]               r_cnt;
    logic [pnr_pkg::Q_W-1:0]  r_ma, r_mb;
    logic                     r_neg;
    logic [P_W-1:0]           r_acc;
    pnr_pkg::t_unit_out       r_out;

    logic [H_W-1:0]           opa, opb;
    logic [2*H_W-1:0]         pp;
    logic [P_W-1:0]           pp_sh;
    logic [P_W-1:0]           rnd;
    logic [63:0]              mag_r;
    logic                     sat_pos, sat_neg;
    logic [pnr_pkg::Q_W-1:0]  ma_in, mb_in;

    // operand magnitudes
    assign ma_in = i_a[pnr_pkg::Q_W-1] ? (~i_a + 1'b1) : i_a;
    assign mb_in = i_b[pnr_pkg::Q_W-1] ? (~i_b + 1'b1) : i_b;

    // partial product select and alignment
    always_comb begin
        opa = r_cnt[1] ? r_ma[pnr_pkg::Q_W-1:H_W] : r_ma[H_W-1:0];
        opb = r_cnt[0] ? r_mb[pnr_pkg::Q_W-1:H_W] : r_mb[H_W-1:0];
        pp  = opa * opb;
        unique case (r_cnt)
            2'd0:    pp_sh = {{(P_W-2*H_W){1'b0}}, pp};
            2'd1,
            2'd2:    pp_sh = {{(P_W-2*H_W){1'b0}}, pp} << H_W;
            default: pp_sh = {{(P_W-2*H_W){1'b0}}, pp} << (2*H_W);
        endcase
    end

    // round to nearest on the magnitude, then saturate
    always_comb begin
        rnd     = r_acc + (P_W)'(64'h8000_0000);
        mag_r   = rnd[P_W-1:32];
        sat_pos = |mag_r[63:pnr_pkg::Q_W-1];
        sat_neg = (|mag_r[63:pnr_pkg::Q_W]) ||
                  (mag_r[pnr_pkg::Q_W-1] && (|mag_r[pnr_pkg::Q_W-2:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_fin      <= 1'b0;
            r_out.done <= 1'b0;
        end else begin
            r_out.done <= 1'b0;
            if (i_start) begin
                r_ma  <= ma_in;
                r_mb  <= mb_in;
                r_neg <= i_a[pnr_pkg::Q_W-1] ^ i_b[pnr_pkg::Q_W-1];
                r_acc <= '0;
                r_cnt <= 2'd0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_acc <= r_acc + pp_sh;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin      <= 1'b0;
                r_out.done <= 1'b1;
                if (r_neg) begin
                    r_out.sat   <= sat_neg;
                    r_out.value <= sat_neg ? pnr_pkg::Q_MIN
                                           : (~mag_r[pnr_pkg::Q_W-1:0] + 1'b1);
                end else begin
                    r_out.sat   <= sat_pos;
                    r_out.value <= sat_pos ? pnr_pkg::Q_MAX : mag_r[pnr_pkg::Q_W-1:0];
                end
            end
        end
    end

    assign o_res = r_out;

endmodule

// ===== sv/pnr_div.sv =====
// Saturating Q16.32 divide, restoring, one quotient bit per cycle
module pnr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pnr_pkg::Q_W-1:0]     i_n,
    input  logic [pnr_pkg::Q_W-1:0]     i_d,
    output pnr_pkg::t_unit_out          o_res
);

    localparam int W     = pnr_pkg::Q_W;
    localparam int INT_W = 16;

    logic                r_chk, r_run, r_fin;
    logic [5:0]          r_cnt;
    logic [W-1:0]        r_mn, r_md, r_rem, r_bits;
    logic                r_neg;
    pnr_pkg::t_unit_out  r_out;

    logic [W:0]          trial;
    logic                ge;
    logic [W:0]          diff;
    logic                ovf;
    logic                sat_pos, sat_neg;

    // one restoring step
    always_comb begin
        trial   = {r_rem, r_bits[W-1]};
        ge      = trial >= {1'b0, r_md};
        diff    = trial - {1'b0, r_md};
        ovf     = {{INT_W{1'b0}}, r_mn[W-1:INT_W]} >= r_md;
        sat_pos = r_bits[W-1];
        sat_neg = r_bits[W-1] && (|r_bits[W-2:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk      <= 1'b0;
            r_run      <= 1'b0;
            r_fin      <= 1'b0;
            r_out.done <= 1'b0;
        end else begin
            r_out.done <= 1'b0;
            if (i_start) begin
                r_mn  <= i_n[W-1] ? (~i_n + 1'b1) : i_n;
                r_md  <= i_d[W-1] ? (~i_d + 1'b1) : i_d;
                r_neg <= i_n[W-1] ^ i_d[W-1];
                r_chk <= 1'b1;
            end else if (r_chk) begin
                // integer part too large: saturate at once
                r_chk <= 1'b0;
                if (ovf) begin
                    r_out.done  <= 1'b1;
                    r_out.sat   <= 1'b1;
                    r_out.value <= r_neg ? pnr_pkg::Q_MIN : pnr_pkg::Q_MAX;
                end else begin
                    r_rem  <= {{INT_W{1'b0}}, r_mn[W-1:INT_W]};
                    r_bits <= {r_mn[INT_W-1:0], {(W-INT_W){1'b0}}};
                    r_cnt  <= '0;
                    r_run  <= 1'b1;
                end
            end else if (r_run) begin
                r_rem  <= ge ? diff[W-1:0] : trial[W-1:0];
                r_bits <= {r_bits[W-2:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(W-1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin      <= 1'b0;
                r_out.done <= 1'b1;
                if (r_neg) begin
                    r_out.sat   <= sat_neg;
                    r_out.value <= sat_neg ? pnr_pkg::Q_MIN : (~r_bits + 1'b1);
                end else begin
                    r_out.sat   <= sat_pos;
                    r_out.value <= sat_pos ? pnr_pkg::Q_MAX : r_bits;
                end
            end
        end
    end

    assign o_res = r_out;

endmodule

// ===== sv/polynomial_newton_root_finder_unit.sv =====
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------
// input     | i_coefficient, i_is_last                  | start && !busy
// result    | o_root, o_status, o_iterations            | o_done, one cycle
// config    | i_cfg_addr, i_cfg_data                    | i_cfg_we
//
// Coefficients are accepted back to back while busy is low. A solve runs k Newton
// steps over the n coefficients: each Horner stage is a check state plus two
// multiplies, and each step ends in a 48-bit restoring divide.
// busy stays high from the last coefficient until the result strobe.
// Synchronous active-low reset idles the sequencer and restores the registers.
// The result receiver cannot stall; o_done marks the one cycle the word is valid.
`include "polynomial_newton_root_finder_unit_assert.svh"

module polynomial_newton_root_finder_unit #(
    parameter int MAX_DEGREE     = pnr_pkg::MAX_DEGREE_DEF,
    parameter int MAX_ITERATIONS = pnr_pkg::MAX_ITERATIONS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [pnr_pkg::Q_W-1:0]        i_coefficient,
    input  logic                                  i_is_last,
    output logic                                  o_done,
    output logic signed [pnr_pkg::Q_W-1:0]        o_root,
    output logic [pnr_pkg::STAT_W-1:0]            o_status,
    output logic [pnr_pkg::ITER_OUT_W-1:0]        o_iterations,
    input  logic                                  i_cfg_we,
    input  logic [pnr_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [pnr_pkg::Q_W-1:0]               i_cfg_data
);

    localparam int W     = pnr_pkg::Q_W;
    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IDXW  = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_ITERATIONS + 1);

    typedef struct packed {
        logic [W-1:0] v;
        logic         sat;
    } t_add;

    // saturating 48-bit add or subtract
    function automatic t_add qaddsub(input logic [W-1:0] a, input logic [W-1:0] b,
                                     input logic sub);
        logic [W:0] s;
        t_add       r;
        s     = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        r.sat = s[W] ^ s[W-1];
        r.v   = r.sat ? (s[W] ? pnr_pkg::Q_MIN : pnr_pkg::Q_MAX) : s[W-1:0];
        return r;
    endfunction

    pnr_pkg::t_state           r_state, n_state;
    logic [W-1:0]              r_store [DEPTH];
    logic [CW-1:0]             r_count;
    logic [IDXW-1:0]           r_i;
    logic [W-1:0]              r_x, r_p, r_dp;
    logic                      r_sat;
    logic [IW-1:0]             r_iters;
    logic [pnr_pkg::STAT_W-1:0] r_status;
    logic [W-1:0]              r_guess;
    logic [pnr_pkg::TOL_W-1:0] r_tol;

    logic                      accept;
    logic [CW-1:0]             count_m1;
    logic [IDXW-1:0]           rd_addr;
    logic [W-1:0]              rd_coef;
    logic                      mul_start, div_start;
    logic [W-1:0]              mul_a;
    pnr_pkg::t_unit_out        mul_res, div_res;
    t_add                      add_dp, add_p, add_x;
    logic [W-1:0]              step_mag;
    logic                      tol_hit;
    logic [IW-1:0]             iters_inc;
    logic [IW+pnr_pkg::ITER_OUT_W-1:0] iters_ext;

    assign accept   = start && !busy;
    assign count_m1 = r_count - CW'(1);

    // single read port into the coefficient store
    always_comb begin
        rd_addr = (r_state == pnr_pkg::S_INIT) ? count_m1[IDXW-1:0] : (r_i - IDXW'(1));
        rd_coef = r_store[rd_addr];
    end

    // Horner and update arithmetic
    always_comb begin
        mul_a     = (r_state == pnr_pkg::S_HCHK) ? r_dp : r_p;
        add_dp    = qaddsub(mul_res.value, r_p, 1'b0);
        add_p     = qaddsub(mul_res.value, rd_coef, 1'b0);
        add_x     = qaddsub(r_x, div_res.value, 1'b1);
        step_mag  = div_res.value[W-1] ? (~div_res.value + 1'b1) : div_res.value;
        tol_hit   = step_mag < {1'b0, r_tol};
        iters_inc = r_iters + IW'(1);
    end

    pnr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (r_x),
        .o_res   (mul_res)
    );

    pnr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (r_p),
        .i_d     (r_dp),
        .o_res   (div_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pnr_pkg::S_IDLE: if (accept && i_is_last) n_state = pnr_pkg::S_INIT;
            pnr_pkg::S_INIT: n_state = pnr_pkg::S_HCHK;
            pnr_pkg::S_HCHK: n_state = (r_i == '0) ? pnr_pkg::S_EVAL : pnr_pkg::S_MDP;
            pnr_pkg::S_MDP:  if (mul_res.done) n_state = pnr_pkg::S_MP;
            pnr_pkg::S_MP:   if (mul_res.done) n_state = pnr_pkg::S_HCHK;
            pnr_pkg::S_EVAL: begin
                n_state = (r_sat || r_dp == '0) ? pnr_pkg::S_DONE : pnr_pkg::S_DIV;
            end
            pnr_pkg::S_DIV: begin
                if (div_res.done) begin
                    if (div_res.sat || add_x.sat || tol_hit ||
                        iters_inc == IW'(MAX_ITERATIONS))
                        n_state = pnr_pkg::S_DONE;
                    else
                        n_state = pnr_pkg::S_INIT;
                end
            end
            pnr_pkg::S_DONE: n_state = pnr_pkg::S_IDLE;
            default:         n_state = pnr_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy      = (r_state != pnr_pkg::S_IDLE);
        o_done    = (r_state == pnr_pkg::S_DONE);
        mul_start = ((r_state == pnr_pkg::S_HCHK) && (r_i != '0)) ||
                    ((r_state == pnr_pkg::S_MDP) && mul_res.done);
        div_start = (r_state == pnr_pkg::S_EVAL) && !r_sat && (r_dp != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pnr_pkg::S_IDLE;
            r_count <= '0;
            r_guess <= pnr_pkg::GUESS_RST;
            r_tol   <= pnr_pkg::TOL_RST;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    pnr_pkg::CFG_INITIAL_GUESS: r_guess <= i_cfg_data;
                    pnr_pkg::CFG_TOLERANCE:     r_tol   <= i_cfg_data[pnr_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end

            // coefficient load, extra words dropped
            if (accept) begin
                if (r_count < CW'(DEPTH)) begin
                    r_store[r_count[IDXW-1:0]] <= i_coefficient;
                    r_count <= r_count + CW'(1);
                end
                if (i_is_last) begin
                    r_x     <= r_guess;
                    r_iters <= '0;
                    r_sat   <= 1'b0;
                end
            end

            unique case (r_state)
                pnr_pkg::S_INIT: begin
                    r_p  <= rd_coef;
                    r_dp <= '0;
                    r_i  <= count_m1[IDXW-1:0];
                end
                pnr_pkg::S_MDP: begin
                    if (mul_res.done) begin
                        r_dp  <= add_dp.v;
                        r_sat <= r_sat | mul_res.sat | add_dp.sat;
                    end
                end
                pnr_pkg::S_MP: begin
                    if (mul_res.done) begin
                        r_p   <= add_p.v;
                        r_sat <= r_sat | mul_res.sat | add_p.sat;
                        r_i   <= r_i - IDXW'(1);
                    end
                end
                pnr_pkg::S_EVAL: begin
                    if (r_sat)
                        r_status <= pnr_pkg::ST_SATURATED;
                    else if (r_dp == '0)
                        r_status <= pnr_pkg::ST_ZERO_DERIV;
                end
                pnr_pkg::S_DIV: begin
                    if (div_res.done) begin
                        r_x     <= add_x.v;
                        r_iters <= iters_inc;
                        r_sat   <= r_sat | div_res.sat | add_x.sat;
                        if (div_res.sat || add_x.sat)
                            r_status <= pnr_pkg::ST_SATURATED;
                        else if (tol_hit)
                            r_status <= pnr_pkg::ST_CONVERGED;
                        else
                            r_status <= pnr_pkg::ST_ITER_LIMIT;
                    end
                end
                pnr_pkg::S_DONE: r_count <= '0;
                default: ;
            endcase
        end
    end

    // result word
    assign iters_ext    = {{pnr_pkg::ITER_OUT_W{1'b0}}, r_iters};
    assign o_root       = r_x;
    assign o_status     = r_status;
    assign o_iterations = iters_ext[pnr_pkg::ITER_OUT_W-1:0];

    // checks
    `PNR_ASSERT_NEXT(a_done_one_cycle, o_done, !o_done && !busy)
    `PNR_ASSERT_NEXT(a_last_starts_solve, start && !busy && i_is_last, busy)
    `PNR_ASSERT_NOW(a_converged_counts, o_done && (o_status == pnr_pkg::ST_CONVERGED), r_iters != '0)
    `PNR_ASSERT_NOW(a_units_exclusive, mul_start, !div_start)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int  DEPTH      = pnr_pkg::MAX_DEGREE_DEF + 1;
    localparam int  ITER_CAP   = pnr_pkg::MAX_ITERATIONS_DEF;
    localparam int  PHASES     = 8;
    localparam int  PHASE_WORDS = 160;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam longint QMAX_L  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint QMIN_L  = -QMAX_L - 1;
    localparam logic signed [pnr_pkg::Q_W-1:0] ONE_Q = 48'sh0001_0000_0000;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic signed [pnr_pkg::Q_W-1:0]      i_coefficient = '0;
    logic                                i_is_last = 1'b0;
    logic                                o_done;
    logic signed [pnr_pkg::Q_W-1:0]      o_root;
    logic [pnr_pkg::STAT_W-1:0]          o_status;
    logic [pnr_pkg::ITER_OUT_W-1:0]      o_iterations;
    logic                                i_cfg_we = 1'b0;
    logic [pnr_pkg::CFG_ADDR_W-1:0]      i_cfg_addr = '0;
    logic [pnr_pkg::Q_W-1:0]             i_cfg_data = '0;

    polynomial_newton_root_finder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_coefficient (i_coefficient),
        .i_is_last     (i_is_last),
        .o_done        (o_done),
        .o_root        (o_root),
        .o_status      (o_status),
        .o_iterations  (o_iterations),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // expected root words, oldest first
    typedef struct {
        logic [pnr_pkg::Q_W-1:0]        root;
        logic [pnr_pkg::STAT_W-1:0]     status;
        logic [pnr_pkg::ITER_OUT_W-1:0] iters;
    } t_root_word;

    t_root_word root_q[$];
    int         errors = 0;
    longint     cycles = 0;

    // predictor state
    longint     coef_mem[DEPTH];
    int         coef_cnt = 0;
    longint     guess_r  = longint'(pnr_pkg::GUESS_RST);
    longint     tol_r    = longint'(pnr_pkg::TOL_RST);
    bit         sat_seen;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // ---------------- fixed-point arithmetic ----------------
    function automatic longint unsigned abs_q(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint clamp_mag(longint unsigned m, bit neg);
        if (neg) begin
            if (m > 64'h8000_0000_0000) begin
                sat_seen = 1'b1;
                return QMIN_L;
            end
            return -longint'(m);
        end
        if (m > 64'h7FFF_FFFF_FFFF) begin
            sat_seen = 1'b1;
            return QMAX_L;
        end
        return longint'(m);
    endfunction

    function automatic longint q_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > QMAX_L) begin
            sat_seen = 1'b1;
            return QMAX_L;
        end
        if (s < QMIN_L) begin
            sat_seen = 1'b1;
            return QMIN_L;
        end
        return s;
    endfunction

    // 24-bit split product, rounded half away from zero on the magnitude
    function automatic longint q_mul(longint a, longint b);
        longint unsigned ma, mb, ah, al, bh, bl, p2, p1, p0, lo, r;
        ma = abs_q(a);
        mb = abs_q(b);
        ah = ma >> 24;
        al = ma & 64'hFF_FFFF;
        bh = mb >> 24;
        bl = mb & 64'hFF_FFFF;
        p2 = ah * bh;
        p1 = ah * bl + al * bh;
        p0 = al * bl;
        lo = p0 + ((p1 & 64'hFF) << 24);
        r  = (p2 << 16) + (p1 >> 8) + (lo >> 32);
        if ((lo & 64'hFFFF_FFFF) >= 64'h8000_0000) r = r + 1;
        return clamp_mag(r, (a < 0) != (b < 0));
    endfunction

    // truncating quotient; divisor is nonzero
    function automatic longint q_div(longint n, longint d);
        longint unsigned mn, md, ip, rem, frac;
        bit neg;
        neg  = (n < 0) != (d < 0);
        mn   = abs_q(n);
        md   = abs_q(d);
        ip   = mn / md;
        rem  = mn % md;
        frac = 0;
        if (ip >= 64'h1_0000) return clamp_mag(64'h8000_0000_0001, neg);
        for (int i = 0; i < 32; i++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= md) begin
                rem  = rem - md;
                frac = frac | 1;
            end
        end
        return clamp_mag((ip << 32) | frac, neg);
    endfunction

    // Newton iteration over the stored coefficients
    function automatic t_root_word solve_poly();
        t_root_word w;
        longint x, p, dp, stp, xn, diff;
        int its, st;
        x  = guess_r;
        its = 0;
        st = pnr_pkg::ST_ITER_LIMIT;
        sat_seen = 1'b0;
        forever begin
            p  = coef_mem[coef_cnt-1];
            dp = 0;
            for (int i = coef_cnt - 1; i > 0; i--) begin
                dp = q_add(q_mul(dp, x), p);
                p  = q_add(q_mul(p, x), coef_mem[i-1]);
            end
            if (sat_seen) begin
                st = pnr_pkg::ST_SATURATED;
                break;
            end
            if (dp == 0) begin
                st = pnr_pkg::ST_ZERO_DERIV;
                break;
            end
            stp  = q_div(p, dp);
            xn   = q_add(x, -stp);
            diff = x - xn;
            x    = xn;
            its++;
            if (sat_seen) begin
                st = pnr_pkg::ST_SATURATED;
                break;
            end
            if (abs_q(diff) < longint'(tol_r)) begin
                st = pnr_pkg::ST_CONVERGED;
                break;
            end
            if (its >= ITER_CAP) break;
        end
        w.root   = x[pnr_pkg::Q_W-1:0];
        w.status = st[pnr_pkg::STAT_W-1:0];
        w.iters  = its[pnr_pkg::ITER_OUT_W-1:0];
        return w;
    endfunction

    // ---------------- driving ----------------
    // one coefficient word; a typed expectation replaces the predicted one
    task automatic send_word(logic signed [pnr_pkg::Q_W-1:0] coef, bit last, bit typed = 0,
                             logic [pnr_pkg::Q_W-1:0] e_root = '0,
                             logic [pnr_pkg::STAT_W-1:0] e_st = pnr_pkg::ST_CONVERGED,
                             logic [pnr_pkg::ITER_OUT_W-1:0] e_it = '0);
        int gap;
        t_root_word w;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_coefficient <= coef;
        i_is_last     <= last;
        do @(posedge i_clk); while (busy);
        // accepted at this edge
        if (coef_cnt < DEPTH) begin
            coef_mem[coef_cnt] = longint'(coef);
            coef_cnt++;
        end
        if (last) begin
            w = solve_poly();
            coef_cnt = 0;
            if (typed) begin
                w.root   = e_root;
                w.status = e_st;
                w.iters  = e_it;
            end
            root_q.push_back(w);
        end
    endtask

    // let the block go idle with no result word outstanding
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (root_q.size() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    // write enable drops for one cycle after each write
    task automatic write_reg(logic [pnr_pkg::CFG_ADDR_W-1:0] addr,
                             logic [pnr_pkg::Q_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (addr == pnr_pkg::CFG_INITIAL_GUESS) guess_r = longint'($signed(data));
        else tol_r = longint'({1'b0, data[pnr_pkg::TOL_W-1:0]});
        @(posedge i_clk);
    endtask

    // random coefficient: mostly small values, some full-width, some extremes
    function automatic logic signed [pnr_pkg::Q_W-1:0] rand_coef();
        longint v;
        case ($urandom_range(0, 19))
            0: return pnr_pkg::Q_MAX;
            1: return pnr_pkg::Q_MIN;
            2: return '0;
            3, 4, 5: return {$urandom, $urandom};
            default: begin
                v = longint'({$urandom, $urandom} & 64'hF_FFFF_FFFF) - 64'sh8_0000_0000;
                return v[pnr_pkg::Q_W-1:0];
            end
        endcase
    endfunction

    // ---------------- directed table ----------------
    typedef struct {
        bit                             is_cfg;
        logic [pnr_pkg::CFG_ADDR_W-1:0] addr;
        logic [pnr_pkg::Q_W-1:0]        value;
        bit                             last;
        bit                             typed;
        logic [pnr_pkg::Q_W-1:0]        e_root;
        logic [pnr_pkg::STAT_W-1:0]     e_st;
        logic [pnr_pkg::ITER_OUT_W-1:0] e_it;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic void add_row(logic [pnr_pkg::Q_W-1:0] v, bit last, bit typed = 0,
                                    logic [pnr_pkg::Q_W-1:0] r = '0,
                                    logic [pnr_pkg::STAT_W-1:0] s = pnr_pkg::ST_CONVERGED,
                                    logic [pnr_pkg::ITER_OUT_W-1:0] it = '0);
        t_dir_row row;
        row = '{0, pnr_pkg::CFG_INITIAL_GUESS, v, last, typed, r, s, it};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [pnr_pkg::CFG_ADDR_W-1:0] a,
                                    logic [pnr_pkg::Q_W-1:0] v);
        t_dir_row row;
        row = '{1, a, v, 0, 0, '0, pnr_pkg::ST_CONVERGED, '0};
        dir_rows.push_back(row);
    endfunction

    // result checker: the receiver never stalls
    always @(posedge i_clk) begin
        t_root_word w;
        if (i_rst_n && o_done) begin
            if (root_q.size() == 0) begin
                report_mismatch("unexpected root word", o_root, 0);
            end else begin
                w = root_q.pop_front();
                if (o_root !== w.root) report_mismatch("root", o_root, w.root);
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_iterations !== w.iters)
                    report_mismatch("iterations", o_iterations, w.iters);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int words, len;
        logic [pnr_pkg::Q_W-1:0] g, t;

        // constant polynomials: zero derivative at the start value
        add_row(48'sh0005_0000_0000, 1, 1, ONE_Q, pnr_pkg::ST_ZERO_DERIV, 0);
        add_row('0, 1, 1, ONE_Q, pnr_pkg::ST_ZERO_DERIV, 0);
        // x - 2 from 1.0: one step to 2.0, then a zero step
        add_row(48'shFFFE_0000_0000, 0);
        add_row(ONE_Q, 1, 1, 48'sh0002_0000_0000, pnr_pkg::ST_CONVERGED, 2);
        // extremes saturate in the first evaluation
        add_row(pnr_pkg::Q_MAX, 0);
        add_row(pnr_pkg::Q_MAX, 1, 1, ONE_Q, pnr_pkg::ST_SATURATED, 0);
        add_row(pnr_pkg::Q_MIN, 0);
        add_row(pnr_pkg::Q_MIN, 1, 1, ONE_Q, pnr_pkg::ST_SATURATED, 0);
        // x^2 + 1 has no real root
        add_row(ONE_Q, 0);
        add_row('0, 0);
        add_row(ONE_Q, 1);
        // too many coefficients: the tail is dropped
        for (int i = 0; i < 11; i++)
            add_row((i % 2) ? ONE_Q : -ONE_Q, i == 10);
        // zero tolerance runs to the iteration cap
        add_cfg(pnr_pkg::CFG_TOLERANCE, '0);
        add_row(48'shFFFE_0000_0000, 0);
        add_row(ONE_Q, 1, 1, 48'sh0002_0000_0000, pnr_pkg::ST_ITER_LIMIT,
                ITER_CAP[pnr_pkg::ITER_OUT_W-1:0]);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                write_reg(dir_rows[i].addr, dir_rows[i].value);
            end else begin
                send_word(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
                          dir_rows[i].e_root, dir_rows[i].e_st, dir_rows[i].e_it);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: g = pnr_pkg::Q_MIN;
                1: g = pnr_pkg::Q_MAX;
                2: g = '0;
                default: g = ($urandom_range(0, 1)) ? {$urandom, $urandom}
                           : 48'(longint'({$urandom} & 32'h7FF_FFFF) * 8 - 64'sh4_0000_0000);
            endcase
            case (ph)
                0: t = '0;
                1: t = {1'b0, {(pnr_pkg::TOL_W){1'b1}}};
                2: t = pnr_pkg::TOL_RST;
                3: t = 48'd1;
                default: t = ($urandom_range(0, 1)) ? {$urandom, $urandom}
                           : 48'($urandom_range(0, 32'h00FF_FFFF));
            endcase
            drain();
            write_reg(pnr_pkg::CFG_INITIAL_GUESS, g);
            write_reg(pnr_pkg::CFG_TOLERANCE, t);
            words = 0;
            while (words < PHASE_WORDS) begin
                case ($urandom_range(0, 19))
                    0: len = $urandom_range(11, 13);
                    1, 2, 3: len = $urandom_range(5, 10);
                    default: len = $urandom_range(1, 4);
                endcase
                for (int k = 0; k < len; k++) send_word(rand_coef(), k == len - 1);
                words += len;
            end
        end

        start <= 1'b0;
        do @(posedge i_clk); while (root_q.size() != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== polynomial_newton_root_finder_unit.f =====
+incdir+sv
sv/pnr_pkg.sv
sv/pnr_mul.sv
sv/pnr_div.sv
sv/polynomial_newton_root_finder_unit.sv
tb/tb.sv
